@@ design/bq_pkg.sv @@
// shared types, constants and tables of the biquad filter
`default_nettype none

package bq_pkg;

    localparam int DEF_SAMPLE_RATE_HZ = 48000;
    localparam int DEF_CORDIC_STEPS   = 16;

    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;
    localparam int CUTOFF_W = 15;
    localparam int QF_W     = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int COEF_W   = 32;
    localparam int NUM_COEF = 5;
    localparam int CORD_W   = 34;
    localparam int RAW_W    = 40;
    localparam int NUM_W    = 64;
    localparam int DEN_W    = 40;
    localparam int FREQ_W   = 17;
    localparam int TABLE_LEN = 24;
    localparam int STEP_W   = $clog2(TABLE_LEN);
    localparam int SHIFT_W  = 3;
    localparam int ACC_W    = 51;
    localparam int PROD_W   = COEF_W + SAMPLE_W;

    localparam logic [MODE_W-1:0]   RST_MODE   = 2'd0;
    localparam logic [CUTOFF_W-1:0] RST_CUTOFF = 15'd12500;
    localparam logic [QF_W-1:0]     RST_Q      = 16'd256;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] QUARTER     = 34'sh040000000;
    localparam logic signed [RAW_W-1:0]  ONE_Q30     = 40'sh0040000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_CUTOFF = 2'd1,
        REG_Q      = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_LP = 2'd0,
        MODE_BP = 2'd1,
        MODE_HP = 2'd2,
        MODE_HP_ALT = 2'd3
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CUTOFF_W-1:0] cutoff;
        logic [QF_W-1:0]     q;
    } t_cfg;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] t_coef_set;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    // atan(2^-i) as a fraction of a full turn, 32-bit scale
    function automatic logic signed [CORD_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [CORD_W-1:0] v;
        case (i)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2FA;
            5'd15: v = 34'sh00000517D;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A30;
            5'd19: v = 34'sh000000518;
            5'd20: v = 34'sh00000028C;
            5'd21: v = 34'sh000000146;
            5'd22: v = 34'sh0000000A3;
            5'd23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/bq_in_if.sv @@
// sample input channel
`default_nettype none

interface bq_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [bq_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ design/bq_out_if.sv @@
// sample output channel
`default_nettype none

interface bq_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [bq_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ design/bq_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none

module bq_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bq_pkg::t_div_req  i_req,
    output bq_pkg::t_div_rsp       o_rsp
);
    import bq_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= i_req.den;
            r_quo  <= i_req.num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

`default_nettype wire

@@ design/bq_coef.sv @@
// coefficient engine: phase, cordic sine and cosine, alpha and normalisation
`default_nettype none

module bq_coef #(
    parameter int SAMPLE_RATE_HZ = bq_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int CORDIC_STEPS   = bq_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_recalc,
    input  wire bq_pkg::t_cfg  i_cfg,
    output logic               o_busy,
    output bq_pkg::t_coef_set  o_coef
);
    import bq_pkg::*;

    localparam int NYQ = SAMPLE_RATE_HZ / 2;
    localparam logic [FREQ_W-1:0] NYQ_F     = FREQ_W'(NYQ);
    localparam logic [FREQ_W-1:0] FC_MAX    = FREQ_W'(NYQ - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam int K_W = $clog2(NUM_COEF);
    localparam logic [K_W-1:0]    LAST_K    = K_W'(NUM_COEF - 1);

    // phase = floor(fc * 2^32 / fs) by an exact reciprocal multiplication
    localparam int LOG_FS     = $clog2(SAMPLE_RATE_HZ);
    localparam int PH_S       = 31 + 2 * LOG_FS;
    localparam int PH_SH      = 2 * LOG_FS - 1;
    localparam int PH_M_W     = 33 + LOG_FS;
    localparam int PH_LO_W    = 26;
    localparam int PH_HI_W    = PH_M_W - PH_LO_W;
    localparam int PH_PROD_W  = FREQ_W + PH_M_W;
    localparam logic [127:0] PH_M_FULL =
        ((128'd1 << PH_S) + 128'(SAMPLE_RATE_HZ) - 128'd1) / 128'(SAMPLE_RATE_HZ);
    localparam logic [PH_LO_W-1:0] PH_M_LO = PH_M_FULL[PH_LO_W-1:0];
    localparam logic [PH_HI_W-1:0] PH_M_HI = PH_M_FULL[PH_M_W-1:PH_LO_W];

    typedef enum logic [3:0] {
        S_IDLE, S_PHASE_GO, S_PHASE_WAIT, S_ROTATE, S_ALPHA_GO, S_ALPHA_WAIT,
        S_SHAPE, S_NORM_GO, S_NORM_WAIT
    } t_state;

    t_state                   r_state;
    logic [STEP_W-1:0]        r_step;
    logic [K_W-1:0]           r_k;
    logic                     r_quad;
    logic signed [CORD_W-1:0] r_x, r_y, r_z;
    logic signed [RAW_W-1:0]  r_alpha;
    logic signed [RAW_W-1:0]  r_raw [NUM_COEF];
    logic [DEN_W-1:0]         r_a0;
    t_coef_set                r_coef;
    logic [FREQ_W+PH_LO_W-1:0] r_ph_lo;

    t_div_req w_req;
    t_div_rsp w_rsp;

    bq_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // clamped cutoff
    logic [FREQ_W-1:0] w_fc;
    assign w_fc = ({2'b00, i_cfg.cutoff} >= NYQ_F) ? FC_MAX : {2'b00, i_cfg.cutoff};

    // upper partial product, lower one is registered in the cycle before
    logic [FREQ_W+PH_HI_W-1:0] w_ph_hi;
    logic [PH_PROD_W-1:0]      w_ph_prod;
    logic [31:0]               w_phase;
    assign w_ph_hi   = w_fc * PH_M_HI;
    assign w_ph_prod = {w_ph_hi, {PH_LO_W{1'b0}}} + PH_PROD_W'(r_ph_lo);
    assign w_phase   = w_ph_prod[PH_SH +: 32];

    // cosine and sine with the quadrant folded back
    logic signed [CORD_W-1:0] w_cw, w_sw;
    logic [CORD_W-1:0]        w_sw_mag;
    assign w_cw     = r_quad ? -r_y : r_x;
    assign w_sw     = r_quad ? r_x : r_y;
    assign w_sw_mag = w_sw[CORD_W-1] ? CORD_W'(-w_sw) : CORD_W'(w_sw);

    logic [QF_W-1:0] w_q;
    assign w_q = (i_cfg.q == '0) ? QF_W'(1) : i_cfg.q;

    // one cordic micro-rotation
    logic signed [CORD_W-1:0] w_dx, w_dy, w_at;
    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;
    assign w_at = atan_turn(r_step);

    // raw coefficients
    logic signed [RAW_W-1:0] w_cw40, w_sw40, w_t;
    logic signed [RAW_W-1:0] w_b0, w_b1, w_b2, w_a0r, w_a1, w_a2, w_a0c;
    logic [SHIFT_W-1:0]      w_sh;

    always_comb begin
        w_cw40 = RAW_W'(w_cw);
        w_sw40 = RAW_W'(w_sw);
        w_t    = ONE_Q30 + w_cw40;
        case (t_mode'(i_cfg.mode))
            MODE_LP: begin
                w_b1 = ONE_Q30 - w_cw40;
                w_b0 = w_b1 >>> 1;
                w_b2 = w_b0;
            end
            MODE_BP: begin
                w_b0 = w_sw40 >>> 1;
                w_b1 = '0;
                w_b2 = -w_b0;
            end
            default: begin
                w_b0 = w_t >>> 1;
                w_b1 = -w_t;
                w_b2 = w_b0;
            end
        endcase
        w_a0r = ONE_Q30 + r_alpha;
        w_a1  = -(w_cw40 <<< 1);
        w_a2  = ONE_Q30 - r_alpha;
        w_a0c = (w_a0r < 40'sd1) ? 40'sd1 : w_a0r;
        // bring a0 below 2^34
        w_sh = '0;
        for (int i = 34; i < RAW_W; i++) begin
            if (w_a0c[i]) w_sh = SHIFT_W'(i - 33);
        end
    end

    // normalisation numerator and saturated quotient
    logic signed [RAW_W-1:0] w_nraw;
    logic [RAW_W-1:0]        w_nmag;
    logic                    w_nneg;
    logic [COEF_W-1:0]       w_nsat;
    assign w_nraw = r_raw[r_k];
    assign w_nneg = w_nraw[RAW_W-1];
    assign w_nmag = w_nneg ? RAW_W'(-w_nraw) : RAW_W'(w_nraw);

    always_comb begin
        if (!w_nneg) begin
            w_nsat = (w_rsp.quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : w_rsp.quot[COEF_W-1:0];
        end else begin
            w_nsat = (w_rsp.quot > NUM_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                : -w_rsp.quot[COEF_W-1:0];
        end
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.num   = '0;
        w_req.den   = '0;
        case (r_state)
            S_ALPHA_GO: begin
                w_req.start = 1'b1;
                w_req.num   = {23'd0, w_sw_mag, 7'd0};
                w_req.den   = {24'd0, w_q};
            end
            S_NORM_GO: begin
                w_req.start = 1'b1;
                w_req.num   = {w_nmag[35:0], 28'd0};
                w_req.den   = r_a0;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_PHASE_GO;
            r_step  <= '0;
            r_k     <= '0;
        end else if (i_recalc) begin
            r_state <= S_PHASE_GO;
        end else begin
            case (r_state)
                S_PHASE_GO: begin
                    r_ph_lo <= w_fc * PH_M_LO;
                    r_state <= S_PHASE_WAIT;
                end
                S_PHASE_WAIT: begin
                    r_quad  <= w_phase[30];
                    r_z     <= w_phase[30] ? CORD_W'(w_phase) - QUARTER
                                           : CORD_W'(w_phase);
                    r_x     <= CORDIC_GAIN;
                    r_y     <= '0;
                    r_step  <= '0;
                    r_state <= S_ROTATE;
                end
                S_ROTATE: begin
                    if (!r_z[CORD_W-1]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) r_state <= S_ALPHA_GO;
                end
                S_ALPHA_GO: begin
                    r_state <= S_ALPHA_WAIT;
                end
                S_ALPHA_WAIT: begin
                    if (w_rsp.done) begin
                        r_alpha <= w_sw[CORD_W-1] ? -$signed(w_rsp.quot[RAW_W-1:0])
                                                  : $signed(w_rsp.quot[RAW_W-1:0]);
                        r_state <= S_SHAPE;
                    end
                end
                S_SHAPE: begin
                    r_raw[0] <= w_b0 >>> w_sh;
                    r_raw[1] <= w_b1 >>> w_sh;
                    r_raw[2] <= w_b2 >>> w_sh;
                    r_raw[3] <= w_a1 >>> w_sh;
                    r_raw[4] <= w_a2 >>> w_sh;
                    r_a0     <= DEN_W'(w_a0c >>> w_sh);
                    r_k      <= '0;
                    r_state  <= S_NORM_GO;
                end
                S_NORM_GO: begin
                    r_state <= S_NORM_WAIT;
                end
                S_NORM_WAIT: begin
                    if (w_rsp.done) begin
                        r_coef[r_k] <= w_nsat;
                        if (r_k == LAST_K) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_NORM_GO;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_coef = r_coef;

endmodule

`default_nettype wire

@@ design/biquad_lp_bp_hp_filter_top.sv @@
// Direct form 1 biquad (lowpass, bandpass, highpass) on Q1.15 samples. A sample
// is taken in the cycle it is offered while input ready is high, and its result
// is registered as it is taken; one sample per clock is sustained while the
// coefficient engine is idle and the output is not stalled, limited by the
// feedback of the last output through the five-product sum. After reset and
// after every write to the mode, cutoff or Q register the coefficient engine
// recomputes the five Q3.28 coefficients: a reciprocal multiply for the phase,
// a CORDIC, a step forming the raw coefficients and six divisions on one serial
// divider; input ready stays low meanwhile and the sample history is kept.
`default_nettype none

module biquad_lp_bp_hp_filter_top #(
    parameter int SAMPLE_RATE_HZ = bq_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int CORDIC_STEPS   = bq_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bq_pkg::CFG_W-1:0]     i_cfg_data,
    bq_in_if.sink                             i_in,
    bq_out_if.source                          o_out
);
    import bq_pkg::*;

    t_cfg      r_cfg;
    t_coef_set w_coef;
    logic      w_busy;
    logic      w_recalc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= RST_MODE;
            r_cfg.cutoff <= RST_CUTOFF;
            r_cfg.q      <= RST_Q;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:   r_cfg.mode   <= i_cfg_data[MODE_W-1:0];
                REG_CUTOFF: r_cfg.cutoff <= i_cfg_data[CUTOFF_W-1:0];
                REG_Q:      r_cfg.q      <= i_cfg_data[QF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_recalc = i_cfg_we && (t_reg_idx'(i_cfg_idx) != REG_NONE);

    bq_coef #(
        .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_recalc(w_recalc),
        .i_cfg   (r_cfg),
        .o_busy  (w_busy),
        .o_coef  (w_coef)
    );

    logic signed [SAMPLE_W-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_valid;
    logic                       w_take;

    assign i_in.ready = !w_busy && (!r_valid || o_out.ready);
    assign w_take     = i_in.valid && i_in.ready;

    logic signed [PROD_W-1:0] w_p0, w_p1, w_p2, w_p3, w_p4;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-29:0] w_shr;
    logic signed [SAMPLE_W-1:0] w_y;

    assign w_p0 = $signed(w_coef[0]) * i_in.sample_in;
    assign w_p1 = $signed(w_coef[1]) * r_x1;
    assign w_p2 = $signed(w_coef[2]) * r_x2;
    assign w_p3 = $signed(w_coef[3]) * r_y1;
    assign w_p4 = $signed(w_coef[4]) * r_y2;

    always_comb begin
        w_acc = ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_p2)
              - ACC_W'(w_p3) - ACC_W'(w_p4) + (ACC_W'(1) <<< 27);
        w_shr = w_acc[ACC_W-1:28];
        // saturate to 16 bits
        if (w_shr > (ACC_W-28)'(32767)) begin
            w_y = 16'sh7FFF;
        end else if (w_shr < -(ACC_W-28)'(32768)) begin
            w_y = 16'sh8000;
        end else begin
            w_y = w_shr[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_x1    <= '0;
            r_x2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
        end else if (w_take) begin
            r_valid      <= 1'b1;
            r_sample_out <= w_y;
            r_x1         <= i_in.sample_in;
            r_x2         <= r_x1;
            r_y1         <= w_y;
            r_y2         <= r_y1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.sample_out = r_sample_out;

endmodule

`default_nettype wire
